/* design/hrdc_pkg.sv */
// ============================================================================
// hrdc_pkg
// Shared types, constants and the signature hash for the replacement engine.
// ============================================================================
package hrdc_pkg;

   localparam int SETS         = 2048;
   localparam int SET_W        = 11;
   localparam int WAYS         = 16;
   localparam int WAY_W        = 4;
   localparam int LINE_W       = 58;
   localparam int PC_W         = 64;
   localparam int SIG_W        = 32;
   localparam int AGE_W        = 8;
   localparam int REUSE_W      = 4;
   localparam int REUSE_MAX    = 15;
   localparam int AGE_MAX      = 255;
   localparam int WINDOW       = 32;
   localparam int PTR_W        = 5;
   localparam int FILL_W       = 6;
   localparam int STRIDE_LIMIT = 64;
   localparam int GROUP        = 4;
   localparam int GROUPS       = WAYS / GROUP;
   localparam int KEY_W        = LINE_W + AGE_W;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = 1;
   localparam int QCNT_W       = 2;

   localparam logic KIND_QUERY  = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [SET_W-1:0]      set_index;
      logic [WAY_W-1:0]      way_index;
      logic [LINE_W-1:0]     line_address;
      logic                  was_hit;
      logic [WAYS-1:0]       valid_mask;
      logic [SIG_W-1:0]      signature;
   } hrdc_item_type;

   typedef struct packed {
      logic                  valid;
      logic [LINE_W-1:0]     tag;
      logic [AGE_W-1:0]      age;
      logic [REUSE_W-1:0]    reuse;
      logic [SIG_W-1:0]      signature;
   } hrdc_way_type;

   typedef hrdc_way_type [WAYS-1:0] hrdc_row_type;

   typedef struct packed {
      logic [LINE_W-1:0]     previous_line;
      logic                  stride_ok;
      logic [WINDOW-1:0]     hit_window;
      logic [PTR_W-1:0]      window_pointer;
      logic [FILL_W-1:0]     window_fill;
   } hrdc_hist_type;

   typedef logic [SIG_W-1:0][PC_W-1:0] hrdc_crc_mask_type;

   // bitwise reflected crc-32 register update, used at elaboration only
   function automatic logic [SIG_W-1:0] crc_core(input logic [PC_W-1:0] v,
                                                 input logic [SIG_W-1:0] init);
      logic [SIG_W-1:0] c;
      c = init;
      for (int i = 0; i < PC_W; i++) begin
         if (c[0] ^ v[i]) begin
            c = (c >> 1) ^ 32'hEDB88320;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic hrdc_crc_mask_type crc_mask_table();
      hrdc_crc_mask_type m;
      logic [SIG_W-1:0]  col;
      m = '0;
      for (int j = 0; j < PC_W; j++) begin
         col = crc_core(PC_W'(1) << j, '0);
         for (int i = 0; i < SIG_W; i++) begin
            m[i][j] = col[i];
         end
      end
      return m;
   endfunction

   localparam hrdc_crc_mask_type CRC_MASK  = crc_mask_table();
   localparam logic [SIG_W-1:0]  CRC_CONST = ~crc_core('0, 32'hFFFFFFFF);

   // crc is linear: one parity per output bit plus the constant from the seed
   function automatic logic [SIG_W-1:0] sig_of(input logic [PC_W-1:0] v);
      logic [SIG_W-1:0] s;
      for (int i = 0; i < SIG_W; i++) begin
         s[i] = (^(v & CRC_MASK[i])) ^ CRC_CONST[i];
      end
      return s;
   endfunction

endpackage

/* design/hybrid_reuse_distance_cache_replacement.sv */
// ============================================================================
// hybrid_reuse_distance_cache_replacement
// Replacement engine: victim selection by stride/reuse history per cache set.
// ============================================================================
// After reset the engine clears all 2048 sets of its memories, with busy
// high. A transaction is taken when start is high and busy is low; a
// two-entry queue lets the next transaction in while the back end works.
// An update is written back, and a query with an invalid way answered, in
// the read state; other queries go through read, reduce and done (memory
// read, key build, two-level compare tree over 16 ways). The result strobes
// on rsp_valid for exactly one cycle, the cycle after the back end finishes
// the query; updates produce no result. The receiver cannot stall responses.
module hybrid_reuse_distance_cache_replacement (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_kind,
   input  logic [hrdc_pkg::SET_W-1:0]  req_set_index,
   input  logic [hrdc_pkg::WAY_W-1:0]  req_way_index,
   input  logic [hrdc_pkg::LINE_W-1:0] req_line_address,
   input  logic [hrdc_pkg::PC_W-1:0]   req_program_counter,
   input  logic                        req_was_hit,
   input  logic [hrdc_pkg::WAYS-1:0]   req_valid_mask,
   output logic                        rsp_valid,
   output logic [hrdc_pkg::WAY_W-1:0]  rsp_victim_way
);

   // queue between front and back
   logic                    q_valid;
   logic                    q_pop;
   logic                    init_done;
   hrdc_pkg::hrdc_item_type q_item;

   // front: accept, hash signature, enqueue
   hrdc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_set_index       (req_set_index),
      .req_way_index       (req_way_index),
      .req_line_address    (req_line_address),
      .req_program_counter (req_program_counter),
      .req_was_hit         (req_was_hit),
      .req_valid_mask      (req_valid_mask),
      .init_done           (init_done),
      .q_pop               (q_pop),
      .q_valid             (q_valid),
      .q_item              (q_item)
   );

   // back: metadata memories, victim pick, update write-back
   hrdc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .init_done      (init_done),
      .rsp_valid      (rsp_valid),
      .rsp_victim_way (rsp_victim_way)
   );

endmodule

/* design/hrdc_ram.sv */
// ============================================================================
// hrdc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module hrdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* design/hrdc_front.sv */
// ============================================================================
// hrdc_front
// Accepts transactions, hashes the signature and queues them for the back end.
// ============================================================================
module hrdc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_kind,
   input  logic [hrdc_pkg::SET_W-1:0]  req_set_index,
   input  logic [hrdc_pkg::WAY_W-1:0]  req_way_index,
   input  logic [hrdc_pkg::LINE_W-1:0] req_line_address,
   input  logic [hrdc_pkg::PC_W-1:0]   req_program_counter,
   input  logic                        req_was_hit,
   input  logic [hrdc_pkg::WAYS-1:0]   req_valid_mask,
   input  logic                        init_done,
   input  logic                        q_pop,
   output logic                        q_valid,
   output hrdc_pkg::hrdc_item_type     q_item
);

   hrdc_pkg::hrdc_item_type            q_ff [hrdc_pkg::QUEUE_DEPTH];
   logic [hrdc_pkg::QPTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [hrdc_pkg::QCNT_W-1:0]        count_ff, count_in;
   hrdc_pkg::hrdc_item_type            item;
   logic                               push;

   assign busy    = (count_ff == hrdc_pkg::QCNT_W'(hrdc_pkg::QUEUE_DEPTH)) || !init_done;
   assign push    = start && !busy;
   assign q_valid = (count_ff != '0);
   assign q_item  = q_ff[rd_ptr_ff];

   always_comb begin
      item.kind         = req_kind;
      item.set_index    = req_set_index;
      item.way_index    = req_way_index;
      item.line_address = req_line_address;
      item.was_hit      = req_was_hit;
      item.valid_mask   = req_valid_mask;
      item.signature    = hrdc_pkg::sig_of(
         {{(hrdc_pkg::PC_W-hrdc_pkg::LINE_W){1'b0}}, req_line_address}
         ^ req_program_counter);
   end

   always_comb begin
      unique case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

/* design/hrdc_back.sv */
// ============================================================================
// hrdc_back
// Reads set metadata, picks victims through a registered compare tree and
// writes back access updates; clears both memories after reset.
// ============================================================================
module hrdc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  hrdc_pkg::hrdc_item_type    q_item,
   output logic                       q_pop,
   output logic                       init_done,
   output logic                       rsp_valid,
   output logic [hrdc_pkg::WAY_W-1:0] rsp_victim_way
);

   localparam int HR_W = hrdc_pkg::FILL_W + 3;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_REDUCE, S_DONE
   } state_type;

   state_type                          state_ff, state_in;
   logic [hrdc_pkg::SET_W-1:0]         clr_ff, clr_in;
   hrdc_pkg::hrdc_item_type            cur_ff;
   logic [hrdc_pkg::KEY_W-1:0]         keys_ff [hrdc_pkg::WAYS];
   logic [hrdc_pkg::KEY_W-1:0]         keys_in [hrdc_pkg::WAYS];
   logic [hrdc_pkg::KEY_W-1:0]         grp_key_ff [hrdc_pkg::GROUPS];
   logic [hrdc_pkg::KEY_W-1:0]         grp_key_in [hrdc_pkg::GROUPS];
   logic [hrdc_pkg::WAY_W-1:0]         grp_idx_ff [hrdc_pkg::GROUPS];
   logic [hrdc_pkg::WAY_W-1:0]         grp_idx_in [hrdc_pkg::GROUPS];
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [hrdc_pkg::WAY_W-1:0]         rsp_way_ff, rsp_way_in;

   hrdc_pkg::hrdc_row_type             meta_rd, meta_wd, new_row;
   hrdc_pkg::hrdc_hist_type            hist_rd, hist_wd, new_hist;
   logic                               meta_we, hist_we;
   logic [hrdc_pkg::SET_W-1:0]         wr_addr;

   logic                               inv_found;
   logic [hrdc_pkg::WAY_W-1:0]         inv_way;
   logic [hrdc_pkg::FILL_W-1:0]        hits;
   logic                               spatial;
   logic [hrdc_pkg::LINE_W-1:0]        tag_dist, sdiff;
   logic                               mism;
   logic [hrdc_pkg::KEY_W-1:0]         best_key;
   logic [hrdc_pkg::WAY_W-1:0]         best_idx;

   hrdc_ram #(
      .WIDTH ($bits(hrdc_pkg::hrdc_row_type)),
      .DEPTH (hrdc_pkg::SETS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (wr_addr),
      .wr_data (meta_wd),
      .rd_addr (q_item.set_index),
      .rd_data (meta_rd)
   );

   hrdc_ram #(
      .WIDTH ($bits(hrdc_pkg::hrdc_hist_type)),
      .DEPTH (hrdc_pkg::SETS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (wr_addr),
      .wr_data (hist_wd),
      .rd_addr (q_item.set_index),
      .rd_data (hist_rd)
   );

   // first invalid way and the mode decision
   always_comb begin
      inv_found = 1'b0;
      inv_way   = '0;
      for (int w = hrdc_pkg::WAYS - 1; w >= 0; w--) begin
         if (!cur_ff.valid_mask[w]) begin
            inv_found = 1'b1;
            inv_way   = hrdc_pkg::WAY_W'(w);
         end
      end
      hits = '0;
      for (int i = 0; i < hrdc_pkg::WINDOW; i++) begin
         hits = hits + hrdc_pkg::FILL_W'(hist_rd.hit_window[i]);
      end
      spatial = hist_rd.stride_ok &&
                (HR_W'(hits) * HR_W'(5) > HR_W'(hist_rd.window_fill) * HR_W'(2));
   end

   // per-way victim keys, larger wins, lower way on a tie
   always_comb begin
      for (int w = 0; w < hrdc_pkg::WAYS; w++) begin
         tag_dist = (meta_rd[w].tag >= cur_ff.line_address) ?
                    meta_rd[w].tag - cur_ff.line_address :
                    cur_ff.line_address - meta_rd[w].tag;
         mism = (meta_rd[w].signature != cur_ff.signature);
         if (spatial) begin
            keys_in[w] = {tag_dist, meta_rd[w].age};
         end else begin
            keys_in[w] = {{(hrdc_pkg::LINE_W-hrdc_pkg::REUSE_W-1){1'b0}},
                          ~meta_rd[w].reuse, mism, meta_rd[w].age};
         end
      end
   end

   // first tree level: groups of four
   always_comb begin
      for (int g = 0; g < hrdc_pkg::GROUPS; g++) begin
         grp_key_in[g] = keys_ff[g*hrdc_pkg::GROUP];
         grp_idx_in[g] = hrdc_pkg::WAY_W'(g*hrdc_pkg::GROUP);
         for (int k = 1; k < hrdc_pkg::GROUP; k++) begin
            if (keys_ff[g*hrdc_pkg::GROUP+k] > grp_key_in[g]) begin
               grp_key_in[g] = keys_ff[g*hrdc_pkg::GROUP+k];
               grp_idx_in[g] = hrdc_pkg::WAY_W'(g*hrdc_pkg::GROUP+k);
            end
         end
      end
   end

   // second tree level
   always_comb begin
      best_key = grp_key_ff[0];
      best_idx = grp_idx_ff[0];
      for (int g = 1; g < hrdc_pkg::GROUPS; g++) begin
         if (grp_key_ff[g] > best_key) begin
            best_key = grp_key_ff[g];
            best_idx = grp_idx_ff[g];
         end
      end
   end

   // access update of the set row and history
   always_comb begin
      new_row = meta_rd;
      for (int w = 0; w < hrdc_pkg::WAYS; w++) begin
         if (meta_rd[w].valid && meta_rd[w].age != hrdc_pkg::AGE_W'(hrdc_pkg::AGE_MAX)) begin
            new_row[w].age = meta_rd[w].age + 1'b1;
         end
         if (cur_ff.way_index == hrdc_pkg::WAY_W'(w)) begin
            new_row[w].age       = '0;
            new_row[w].signature = cur_ff.signature;
            if (cur_ff.was_hit) begin
               if (meta_rd[w].reuse != hrdc_pkg::REUSE_W'(hrdc_pkg::REUSE_MAX)) begin
                  new_row[w].reuse = meta_rd[w].reuse + 1'b1;
               end
            end else begin
               new_row[w].valid = 1'b1;
               new_row[w].tag   = cur_ff.line_address;
               new_row[w].reuse = hrdc_pkg::REUSE_W'(1);
            end
         end
      end
      new_hist = hist_rd;
      sdiff = (cur_ff.line_address >= hist_rd.previous_line) ?
              cur_ff.line_address - hist_rd.previous_line :
              hist_rd.previous_line - cur_ff.line_address;
      if (hist_rd.previous_line != '0) begin
         new_hist.stride_ok = (sdiff != '0) &&
                              (sdiff < hrdc_pkg::LINE_W'(hrdc_pkg::STRIDE_LIMIT));
      end
      new_hist.previous_line                     = cur_ff.line_address;
      new_hist.hit_window[hist_rd.window_pointer] = cur_ff.was_hit;
      new_hist.window_pointer                    = hist_rd.window_pointer + 1'b1;
      if (hist_rd.window_fill < hrdc_pkg::FILL_W'(hrdc_pkg::WINDOW)) begin
         new_hist.window_fill = hist_rd.window_fill + 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      q_pop        = 1'b0;
      meta_we      = 1'b0;
      hist_we      = 1'b0;
      wr_addr      = cur_ff.set_index;
      meta_wd      = new_row;
      hist_wd      = new_hist;
      rsp_valid_in = 1'b0;
      rsp_way_in   = rsp_way_ff;
      unique case (state_ff)
         S_CLEAR: begin
            meta_we = 1'b1;
            hist_we = 1'b1;
            wr_addr = clr_ff;
            meta_wd = '0;
            hist_wd = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == hrdc_pkg::SET_W'(hrdc_pkg::SETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (cur_ff.kind == hrdc_pkg::KIND_UPDATE) begin
               meta_we  = 1'b1;
               hist_we  = 1'b1;
               state_in = S_IDLE;
            end else if (inv_found) begin
               rsp_valid_in = 1'b1;
               rsp_way_in   = inv_way;
               state_in     = S_IDLE;
            end else begin
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_way_in   = best_idx;
            state_in     = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_way_ff <= rsp_way_in;
      if (q_pop) begin
         cur_ff <= q_item;
      end
      if (state_ff == S_READ) begin
         keys_ff <= keys_in;
      end
      if (state_ff == S_REDUCE) begin
         grp_key_ff <= grp_key_in;
         grp_idx_ff <= grp_idx_in;
      end
   end

   assign init_done      = (state_ff != S_CLEAR);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_victim_way = rsp_way_ff;

`ifndef SYNTH
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(cur_ff.kind) == hrdc_pkg::KIND_QUERY))
      else $error("response for an update");
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      meta_we |-> (state_ff == S_CLEAR || cur_ff.kind == hrdc_pkg::KIND_UPDATE))
      else $error("metadata write outside clear or update");
   a_rsp_timing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == S_DONE || $past(state_ff) == S_READ))
      else $error("response out of sequence");
`endif

endmodule
